[rtl/core/miq_pkg.sv]
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and constants for the middle-insert queue.
// ----------------------------------------------------------------------------
`default_nettype none

package miq_pkg;

  localparam int unsigned MIQ_DEPTH = 1024;
  localparam int unsigned MIQ_ID_W  = 31;
  localparam int unsigned MIQ_OP_W  = 2;
  localparam int unsigned MIQ_ST_W  = 2;

  typedef enum logic [MIQ_OP_W-1:0] {
    OP_PUSH_BACK = 2'd0,
    OP_PUSH_MID  = 2'd1,
    OP_POP       = 2'd2
  } miq_opcode_e;

  typedef enum logic [MIQ_ST_W-1:0] {
    ST_PUSHED     = 2'd0,
    ST_POPPED     = 2'd1,
    ST_POP_EMPTY  = 2'd2,
    ST_PUSH_FULL  = 2'd3
  } miq_status_e;

  typedef enum logic [1:0] {
    MIQ_IDLE,
    MIQ_EXEC,
    MIQ_FIX
  } miq_state_e;

endpackage

`default_nettype wire

[rtl/core/miq_if.sv]
// ----------------------------------------------------------------------------
// miq_if
// Valid/ready channels for queue commands and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface miq_cmd_if;
  import miq_pkg::*;

  logic                valid;
  logic                ready;
  logic [MIQ_OP_W-1:0] opcode;
  logic [MIQ_ID_W-1:0] item_id;

  modport source (output valid, opcode, item_id, input ready);
  modport sink   (input valid, opcode, item_id, output ready);
endinterface

interface miq_rsp_if;
  import miq_pkg::*;

  logic                valid;
  logic                ready;
  logic [MIQ_ID_W-1:0] popped_id;
  logic [MIQ_ST_W-1:0] status;

  modport source (output valid, popped_id, status, input ready);
  modport sink   (input valid, popped_id, status, output ready);
endinterface

`default_nettype wire

[rtl/core/miq_ram.sv]
// ----------------------------------------------------------------------------
// miq_ram
// Generic synchronous RAM: one write port, NRD read ports, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module miq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned NRD   = 1,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i [NRD],
  output logic      [WIDTH-1:0] rdata_o [NRD]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    for (int r = 0; r < NRD; r++) begin
      rdata_o[r] <= mem[raddr_i[r]];
    end
  end

endmodule

`default_nettype wire

[rtl/core/middle_insert_queue_top.sv]
// ----------------------------------------------------------------------------
// middle_insert_queue_top
// Ordered id queue with push to back, push to middle and pop from front.
// ----------------------------------------------------------------------------
// Commands arrive on cmd_i (opcode, item_id); each gives exactly one response
// on rsp_o (popped_id, status). The queue is a linked list held in two
// synchronous RAMs: slot values and slot links, with released slots kept on
// a free list. A pointer to the entry at position ceil(n/2) is maintained, so
// every command costs a fixed number of RAM accesses.
// Sequence: a command is taken in the idle state and its RAM reads return in the
// next cycle, where push to back and pop finish.
// A push to the middle of a queue of two or more needs a second link write
// through the single write port, made in the fix-up state. Errors (pop on empty,
// push on full) are answered from the idle state with no state change.
// The response sits in an output register; cmd_i is ready again while that
// register is being taken. It stalls while a command runs or a response waits.
// Reset clears the pointers and counts at once; RAM contents need no clearing
// because no entry is read before it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module middle_insert_queue_top #(
  parameter int unsigned DEPTH = miq_pkg::MIQ_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  miq_cmd_if.sink    cmd_i,
  miq_rsp_if.source  rsp_o
);
  import miq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  miq_state_e          state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [AW-1:0]       tail_q, tail_d;
  logic [AW-1:0]       middle_q, middle_d;
  logic [AW-1:0]       free_head_q, free_head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       free_count_q, free_count_d;
  logic [CW-1:0]       fresh_next_q, fresh_next_d;

  logic                pop_q, pop_d;
  logic                mid_q, mid_d;
  logic [MIQ_ID_W-1:0] id_q, id_d;
  logic [AW-1:0]       fix_addr_q, fix_addr_d;
  logic [AW-1:0]       fix_data_q, fix_data_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [MIQ_ID_W-1:0] popped_q, popped_d;
  miq_status_e         status_q, status_d;

  logic                cmd_ready;
  logic                cmd_accept;
  logic                cmd_pop;
  logic                q_empty;
  logic                q_full;
  logic                n_even;
  logic                use_free;
  logic [AW-1:0]       slot;

  logic                link_we;
  logic [AW-1:0]       link_waddr;
  logic [AW-1:0]       link_wdata;
  logic [AW-1:0]       link_raddr [2];
  logic [AW-1:0]       link_rdata [2];

  logic                val_we;
  logic [AW-1:0]       val_waddr;
  logic [MIQ_ID_W-1:0] val_wdata;
  logic [AW-1:0]       val_raddr  [1];
  logic [MIQ_ID_W-1:0] val_rdata  [1];

  // opcode 3 decodes as a pop
  assign cmd_pop    = !((cmd_i.opcode == OP_PUSH_BACK) || (cmd_i.opcode == OP_PUSH_MID));
  assign cmd_accept = cmd_i.valid && cmd_ready;
  assign q_empty    = (count_q == '0);
  assign q_full     = (count_q == CW'(DEPTH));
  assign n_even     = !count_q[0];
  assign use_free   = (free_count_q != '0);
  assign slot       = use_free ? free_head_q : fresh_next_q[AW-1:0];

  // Reads are issued from the idle cycle; state is unchanged until they return
  assign link_raddr[0] = cmd_pop ? head_q : free_head_q;
  assign link_raddr[1] = middle_q;
  assign val_raddr[0]  = head_q;

  miq_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH),
    .NRD   (2)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  miq_ram #(
    .WIDTH (MIQ_ID_W),
    .DEPTH (DEPTH),
    .NRD   (1)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= MIQ_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      middle_q     <= '0;
      free_head_q  <= '0;
      count_q      <= '0;
      free_count_q <= '0;
      fresh_next_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      middle_q     <= middle_d;
      free_head_q  <= free_head_d;
      count_q      <= count_d;
      free_count_q <= free_count_d;
      fresh_next_q <= fresh_next_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q      <= pop_d;
    mid_q      <= mid_d;
    id_q       <= id_d;
    fix_addr_q <= fix_addr_d;
    fix_data_q <= fix_data_d;
    popped_q   <= popped_d;
    status_q   <= status_d;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    middle_d     = middle_q;
    free_head_d  = free_head_q;
    count_d      = count_q;
    free_count_d = free_count_q;
    fresh_next_d = fresh_next_q;
    pop_d        = pop_q;
    mid_d        = mid_q;
    id_d         = id_q;
    fix_addr_d   = fix_addr_q;
    fix_data_d   = fix_data_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    popped_d     = popped_q;
    status_d     = status_q;
    cmd_ready    = 1'b0;
    link_we      = 1'b0;
    link_waddr   = head_q;
    link_wdata   = free_head_q;
    val_we       = 1'b0;
    val_waddr    = slot;
    val_wdata    = id_q;

    case (state_q)
      MIQ_IDLE: begin
        cmd_ready = !rsp_valid_q || rsp_o.ready;
        if (cmd_accept) begin
          pop_d = cmd_pop;
          mid_d = (cmd_i.opcode == OP_PUSH_MID);
          id_d  = cmd_i.item_id;
          if (cmd_pop && q_empty) begin
            rsp_valid_d = 1'b1;
            popped_d    = '0;
            status_d    = ST_POP_EMPTY;
          end else if (!cmd_pop && q_full) begin
            rsp_valid_d = 1'b1;
            popped_d    = '0;
            status_d    = ST_PUSH_FULL;
          end else begin
            state_d = MIQ_EXEC;
          end
        end
      end

      MIQ_EXEC: begin
        if (pop_q) begin
          // unlink the head and return its slot to the free list
          head_d       = link_rdata[0];
          if (n_even) begin
            middle_d = link_rdata[1];
          end
          link_we      = 1'b1;
          link_waddr   = head_q;
          link_wdata   = free_head_q;
          free_head_d  = head_q;
          free_count_d = free_count_q + CW'(1);
          count_d      = count_q - CW'(1);
          rsp_valid_d  = 1'b1;
          popped_d     = val_rdata[0];
          status_d     = ST_POPPED;
          state_d      = MIQ_IDLE;
        end else begin
          if (use_free) begin
            free_head_d  = link_rdata[0];
            free_count_d = free_count_q - CW'(1);
          end else begin
            fresh_next_d = fresh_next_q + CW'(1);
          end
          val_we  = 1'b1;
          count_d = count_q + CW'(1);
          if (mid_q && (count_q > CW'(1))) begin
            // new slot takes over the middle's link; middle is repointed next
            link_we    = 1'b1;
            link_waddr = slot;
            link_wdata = link_rdata[1];
            fix_addr_d = middle_q;
            fix_data_d = slot;
            if (n_even) begin
              middle_d = slot;
            end
            state_d = MIQ_FIX;
          end else begin
            if (q_empty) begin
              head_d   = slot;
              middle_d = slot;
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_q;
              link_wdata = slot;
              if (n_even) begin
                middle_d = link_rdata[1];
              end
            end
            tail_d      = slot;
            rsp_valid_d = 1'b1;
            popped_d    = '0;
            status_d    = ST_PUSHED;
            state_d     = MIQ_IDLE;
          end
        end
      end

      MIQ_FIX: begin
        link_we     = 1'b1;
        link_waddr  = fix_addr_q;
        link_wdata  = fix_data_q;
        rsp_valid_d = 1'b1;
        popped_d    = '0;
        status_d    = ST_PUSHED;
        state_d     = MIQ_IDLE;
      end

      default: begin
        state_d = MIQ_IDLE;
      end
    endcase
  end

  assign cmd_i.ready     = cmd_ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.popped_id = popped_q;
  assign rsp_o.status    = status_q;

  // every slot ever taken is either queued or on the free list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW+1)'(count_q) + (CW+1)'(free_count_q) == (CW+1)'(fresh_next_q))
    else $error("slot accounting broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MIQ_FIX) |-> ($past(state_q) == MIQ_EXEC) && $past(mid_q))
    else $error("link fix-up without a middle insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept |-> (!rsp_valid_q || rsp_o.ready))
    else $error("command taken while a response waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != MIQ_IDLE) |-> !cmd_i.ready)
    else $error("command port ready while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MIQ_EXEC) |=> (rsp_valid_q || (state_q == MIQ_FIX)))
    else $error("executed command gave no response");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the middle-insert queue.
// ----------------------------------------------------------------------------
// Commands are built up front into a list that a clocked driver plays out with
// random gaps. At each accepted command, a plain array model of the queue works
// out the response, and that response is stored in order. A clocked monitor
// compares every response that the block returns with the oldest stored one.
// The stimulus has a short directed opening, then a random mix of pushes and
// pops that leaves the queue a few hundred entries deep, and then a drain to
// empty with a final pop on empty. The receiver stalls at random, and once it
// holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import miq_pkg::*;

  localparam int unsigned        DEPTH           = MIQ_DEPTH;
  localparam logic [MIQ_OP_W-1:0] OP_SPARE       = 2'd3;  // unused code, decoded as a pop
  localparam logic [MIQ_ID_W-1:0] ID_MAX         = {MIQ_ID_W{1'b1}};
  localparam int unsigned        RANDOM_CMDS     = 550;
  localparam int unsigned        PRESSURE_AT     = 250;
  localparam int unsigned        PRESSURE_CYCLES = 300;
  localparam int unsigned        DRAIN_CYCLES    = 20;

  typedef struct {
    logic [MIQ_OP_W-1:0] opcode;
    logic [MIQ_ID_W-1:0] item_id;
    int unsigned         gap;
  } command_t;

  typedef struct {
    logic [MIQ_ID_W-1:0] popped_id;
    miq_status_e         status;
  } reply_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  miq_cmd_if cmd_bus ();
  miq_rsp_if rsp_bus ();

  middle_insert_queue_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  // Stimulus list, model of the queue contents and responses still awaited
  command_t            pending_cmds[$];
  logic [MIQ_ID_W-1:0] queued_ids[$];
  reply_t              awaited_replies[$];

  int unsigned gen_depth;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned replies_seen;
  int unsigned mismatches;
  int unsigned peak_depth;
  int unsigned status_seen[4];
  bit          pressure_done;
  command_t    next_cmd;
  reply_t      want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Model of the queue: work out the response to one accepted command
  function automatic void apply_command(input logic [MIQ_OP_W-1:0] op,
                                        input logic [MIQ_ID_W-1:0] id);
    reply_t      rep;
    int unsigned n;
    n = queued_ids.size();
    rep.popped_id = '0;
    if (op == OP_POP || op == OP_SPARE) begin
      if (n == 0) begin
        rep.status = ST_POP_EMPTY;
      end else begin
        rep.popped_id = queued_ids.pop_front();
        rep.status    = ST_POPPED;
      end
    end else if (n >= DEPTH) begin
      rep.status = ST_PUSH_FULL;
    end else begin
      rep.status = ST_PUSHED;
      // insert just after position ceil(n/2); short queues simply append
      if (op == OP_PUSH_MID && n >= 2) queued_ids.insert((n + 1) / 2, id);
      else                             queued_ids.push_back(id);
      if (queued_ids.size() > peak_depth) peak_depth = queued_ids.size();
    end
    awaited_replies.push_back(rep);
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90)         return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MIQ_OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_PUSH_BACK;
    if (r < 70) return OP_PUSH_MID;
    if (r < 94) return OP_POP;
    return OP_SPARE;
  endfunction

  function automatic logic [MIQ_ID_W-1:0] random_id();
    return MIQ_ID_W'($urandom());
  endfunction

  // Queue a command and keep a rough depth count to steer the later phases
  task automatic add_command(input logic [MIQ_OP_W-1:0] op,
                             input logic [MIQ_ID_W-1:0] id, input bit calm);
    command_t c;
    c.opcode  = op;
    c.item_id = id;
    c.gap     = pick_gap(calm);
    pending_cmds.push_back(c);
    if (op == OP_POP || op == OP_SPARE) begin
      if (gen_depth > 0) gen_depth--;
    end else if (gen_depth < DEPTH) begin
      gen_depth++;
    end
  endtask

  // Driver: hold the command while stalled, advance on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.valid   <= 1'b0;
      cmd_bus.opcode  <= OP_PUSH_BACK;
      cmd_bus.item_id <= '0;
      idle_cycles     <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) apply_command(cmd_bus.opcode, cmd_bus.item_id);
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_cmds.size() == 0) begin
          cmd_bus.valid <= 1'b0;
        end else if (idle_cycles < pending_cmds[0].gap) begin
          cmd_bus.valid <= 1'b0;
          idle_cycles   <= idle_cycles + 1;
        end else begin
          next_cmd         = pending_cmds.pop_front();
          cmd_bus.valid   <= 1'b1;
          cmd_bus.opcode  <= next_cmd.opcode;
          cmd_bus.item_id <= next_cmd.item_id;
          idle_cycles     <= 0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off after PRESSURE_AT responses
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= 0;
      pressure_done <= 1'b0;
    end else if (!pressure_done && replies_seen >= PRESSURE_AT) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end else if (stall_left != 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      automatic int unsigned r = $urandom_range(0, 99);
      if (r < 70) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b0;
        stall_left    <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // Monitor: compare each response transfer with the oldest one awaited
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      replies_seen <= replies_seen + 1;
      status_seen[rsp_bus.status]++;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, expected none, actual popped_id %h status %0d",
                 $time, rsp_bus.popped_id, rsp_bus.status);
      end else begin
        want = awaited_replies.pop_front();
        if (rsp_bus.popped_id !== want.popped_id) begin
          mismatches++;
          $display("%0t: popped_id expected %h actual %h",
                   $time, want.popped_id, rsp_bus.popped_id);
        end
        if (rsp_bus.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp_bus.status);
        end
      end
    end
  end

  initial begin
    cmd_bus.valid   = 1'b0;
    cmd_bus.opcode  = OP_PUSH_BACK;
    cmd_bus.item_id = '0;
    rsp_bus.ready   = 1'b0;
    replies_seen    = 0;
    mismatches      = 0;
    peak_depth      = 0;
    gen_depth       = 0;
    status_seen     = '{default: 0};

    // Directed opening: empty pops, short-queue appends, odd and even middles
    add_command(OP_POP, random_id(), 1'b1);
    add_command(OP_SPARE, random_id(), 1'b0);
    add_command(OP_PUSH_MID, '0, 1'b1);
    add_command(OP_PUSH_MID, ID_MAX, 1'b0);
    add_command(OP_PUSH_MID, 31'h2AAA_AAAA, 1'b1);
    add_command(OP_PUSH_MID, 31'h5555_5555, 1'b0);
    add_command(OP_PUSH_BACK, 31'h1, 1'b1);
    add_command(OP_PUSH_MID, random_id(), 1'b0);
    add_command(OP_POP, '0, 1'b1);
    add_command(OP_SPARE, ID_MAX, 1'b0);
    add_command(OP_POP, random_id(), 1'b1);
    add_command(OP_PUSH_BACK, ID_MAX, 1'b0);
    add_command(OP_PUSH_MID, random_id(), 1'b1);
    while (gen_depth > 0) add_command(OP_POP, random_id(), 1'b0);
    add_command(OP_POP, random_id(), 1'b1);

    // Random mix, with a stretch of back-to-back traffic every third block
    for (int unsigned i = 0; i < RANDOM_CMDS; i++)
      add_command(pick_op(), random_id(), (i / 100) % 3 == 2);

    // Drain to empty, then pop once more on the empty queue
    while (gen_depth > 0)
      add_command($urandom_range(0, 9) == 0 ? OP_SPARE : OP_POP, random_id(),
                  $urandom_range(0, 1) == 0);
    add_command(OP_SPARE, random_id(), 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || cmd_bus.valid || awaited_replies.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d responses: %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full",
             replies_seen, status_seen[ST_PUSHED], status_seen[ST_POPPED],
             status_seen[ST_POP_EMPTY], status_seen[ST_PUSH_FULL]);
    $display("Deepest queue held %0d of %0d entries", peak_depth, DEPTH);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/miq_pkg.sv
rtl/core/miq_if.sv
rtl/core/miq_ram.sv
rtl/core/middle_insert_queue_top.sv
tb/testbench.sv
